// ----- rtl/iskd_pkg.sv -----
package iskd_pkg;

    localparam int KEY_W = 32;
    localparam int TAG_W = 16;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic                    last;
    } t_item;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } t_state;

endpackage

// ----- rtl/iskd_front.sv -----
module iskd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  iskd_pkg::t_item i_item,
    output logic           o_item_valid,
    output iskd_pkg::t_item o_item,
    input  logic           i_pop
);

    iskd_pkg::t_item r_mem [2];
    logic            r_wr_ptr, n_wr_ptr;
    logic            r_rd_ptr, n_rd_ptr;
    logic [1:0]      r_cnt, n_cnt;
    logic            push;
    logic            pop;

    assign o_stall      = (r_cnt == 2'd2);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_mem[r_rd_ptr];

    assign push = i_valid && !o_stall;
    assign pop  = i_pop && o_item_valid;

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- rtl/iskd_chain.sv -----
module iskd_chain #(
    parameter int MAX_RECORDS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_item_valid,
    input  iskd_pkg::t_item                   i_item,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [iskd_pkg::KEY_W-1:0] o_key,
    output logic [iskd_pkg::TAG_W-1:0]        o_tag,
    output logic                              o_last,
    output logic                              o_overflowed
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    iskd_pkg::t_state r_state, n_state;

    logic signed [iskd_pkg::KEY_W-1:0] r_key [MAX_RECORDS];
    logic [iskd_pkg::TAG_W-1:0]        r_tag [MAX_RECORDS];
    logic [MAX_RECORDS-1:0]            ge;

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_drop, n_drop;
    logic             full;
    logic             insert;
    logic             emit;
    logic             final_beat;

    logic                              r_out_valid;
    logic signed [iskd_pkg::KEY_W-1:0] r_out_key;
    logic [iskd_pkg::TAG_W-1:0]        r_out_tag;
    logic                              r_out_last;
    logic                              r_out_ovf;

    assign full       = (r_count == CNT_W'(MAX_RECORDS));
    assign final_beat = (r_count == CNT_W'(1));

    // control outputs of the load/emit sequencer
    always_comb begin
        o_pop  = 1'b0;
        insert = 1'b0;
        emit   = 1'b0;
        unique case (r_state)
            iskd_pkg::ST_LOAD: begin
                o_pop  = i_item_valid;
                insert = i_item_valid && !full;
            end
            iskd_pkg::ST_EMIT: begin
                emit = !r_out_valid || !i_stall;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iskd_pkg::ST_LOAD: begin
                if (o_pop && i_item.last) begin
                    n_state = iskd_pkg::ST_EMIT;
                end
            end
            iskd_pkg::ST_EMIT: begin
                if (emit && final_beat) begin
                    n_state = iskd_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = iskd_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_drop  = r_drop;
        if (insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (emit) begin
            n_count = r_count - CNT_W'(1);
        end
        if (o_pop && full) begin
            n_drop = 1'b1;
        end else if (emit && final_beat) begin
            n_drop = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iskd_pkg::ST_LOAD;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_key  <= r_key[0];
            r_out_tag  <= r_tag[0];
            r_out_last <= final_beat;
            r_out_ovf  <= r_drop;
        end
    end

    // On insert, each cell holds if its key is >= the new one (keeps equal keys ahead),
    // takes the new record at the boundary, and otherwise takes its head-side neighbor.
    for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
        assign ge[i] = (CNT_W'(i) < r_count) && (r_key[i] >= i_item.key);

        always_ff @(posedge i_clk) begin
            if (insert) begin
                if (!ge[i]) begin
                    if (i == 0) begin
                        r_key[i] <= i_item.key;
                        r_tag[i] <= i_item.tag;
                    end else if (ge[(i == 0) ? 0 : i-1]) begin
                        r_key[i] <= i_item.key;
                        r_tag[i] <= i_item.tag;
                    end else begin
                        r_key[i] <= r_key[(i == 0) ? 0 : i-1];
                        r_tag[i] <= r_tag[(i == 0) ? 0 : i-1];
                    end
                end
            end else if (emit && (i < MAX_RECORDS - 1)) begin
                r_key[i] <= r_key[(i < MAX_RECORDS - 1) ? i+1 : i];
                r_tag[i] <= r_tag[(i < MAX_RECORDS - 1) ? i+1 : i];
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_key        = r_out_key;
    assign o_tag        = r_out_tag;
    assign o_last       = r_out_last;
    assign o_overflowed = r_out_ovf;

endmodule

// ----- rtl/insertion_sort_key_descending_unit.sv -----
// Stable descending record sorter. Records (signed key, tag) enter one beat
// at a time; a two-entry input queue feeds a chain of MAX_RECORDS cells that
// compare the new key against every stored key in parallel and shift to make
// room, so each record is inserted in place. After the beat marked last, the
// chain shifts out one record per cycle while the output is not stalled, from
// the head (highest key first, equal keys in arrival order), flagging the
// final beat and whether any record of the set was dropped because the chain
// was full. While emitting, the input queue holds up to two beats of the next
// set before stalling.
module insertion_sort_key_descending_unit #(
    parameter int MAX_RECORDS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [iskd_pkg::KEY_W-1:0] i_sort_key,
    input  logic [iskd_pkg::TAG_W-1:0]        i_record_tag,
    input  logic                              i_last_item,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [iskd_pkg::KEY_W-1:0] o_out_key,
    output logic [iskd_pkg::TAG_W-1:0]        o_out_tag,
    output logic                              o_out_last,
    output logic                              o_overflowed
);

    iskd_pkg::t_item in_item;
    iskd_pkg::t_item q_item;
    logic            q_valid;
    logic            q_pop;

    assign in_item.key  = i_sort_key;
    assign in_item.tag  = i_record_tag;
    assign in_item.last = i_last_item;

    iskd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_item       (in_item),
        .o_item_valid (q_valid),
        .o_item       (q_item),
        .i_pop        (q_pop)
    );

    iskd_chain #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_key        (o_out_key),
        .o_tag        (o_out_tag),
        .o_last       (o_out_last),
        .o_overflowed (o_overflowed)
    );

endmodule
